### design/cbez_pkg.sv
// Package for the cubic Bezier point evaluator: item types, stage widths
// and lane counts. No dependencies.
package cbez_pkg;

	// Fixed-point layout
	localparam int unsigned CoordW = 32;
	localparam int unsigned TW     = 16;
	localparam int unsigned FracW  = 16;
	localparam int unsigned DiffW  = CoordW + 1;
	localparam int unsigned ProdW  = DiffW + TW + 1;

	// Lerps per de Casteljau level, x lanes first then y lanes
	localparam int unsigned L1Lanes = 6;
	localparam int unsigned L2Lanes = 4;
	localparam int unsigned L3Lanes = 2;

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [DiffW-1:0]  diff_t;
	typedef logic signed [ProdW-1:0]  prod_t;
	typedef logic        [TW-1:0]     tpar_t;

	typedef struct packed {
		coord_t p0_x;
		coord_t p0_y;
		coord_t p1_x;
		coord_t p1_y;
		coord_t p2_x;
		coord_t p2_y;
		coord_t p3_x;
		coord_t p3_y;
		tpar_t  t_frac;
	} req_t;

	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
	} rsp_t;

	// Difference of two coordinates, sign-extended to 33 bits
	function automatic diff_t coord_diff(coord_t a, coord_t b);
		diff_t da;
		diff_t db;
		da = {a[CoordW-1], a};
		db = {b[CoordW-1], b};
		return db - da;
	endfunction

	// Signed difference times unsigned t; the product always fits
	function automatic prod_t scale_diff(diff_t d, tpar_t t);
		prod_t de;
		prod_t te;
		de = prod_t'(d);
		te = prod_t'({1'b0, t});
		return de * te;
	endfunction

	// a + floor(p / 2^16), wraps to 32 bits (the true value always fits)
	function automatic coord_t lerp_sum(coord_t a, prod_t p);
		return a + coord_t'(p[FracW +: CoordW]);
	endfunction

endpackage

### design/cubic_bezier_point_eval.sv
// Throughput: one item per cycle while the output is not stalled; three de
// Casteljau levels of three stages each (difference, 33x17 multiply, shift and
// add), each stage with a valid bit.
// A stalled output backs up only full stages; bubbles still take new items.
// Reset (arst_n, asynchronous) clears all valid bits; data registers are not reset.
// Depends on cbez_pkg.
module cubic_bezier_point_eval (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  cbez_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output cbez_pkg::rsp_t rsp
);
	import cbez_pkg::*;

	// Valid bits and per-stage load enables
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic valid_s6, valid_s7, valid_s8, valid_s9;
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7, adv8, adv9;

	// Level 1 operands
	coord_t l1_a [L1Lanes];
	coord_t l1_b [L1Lanes];

	// Level 1 registers
	coord_t a_s1    [L1Lanes];
	diff_t  diff_s1 [L1Lanes];
	tpar_t  t_s1;
	coord_t a_s2    [L1Lanes];
	prod_t  prod_s2 [L1Lanes];
	tpar_t  t_s2;
	coord_t r_s3    [L1Lanes];
	tpar_t  t_s3;

	// Level 2 operands and registers
	coord_t l2_a [L2Lanes];
	coord_t l2_b [L2Lanes];
	coord_t a_s4    [L2Lanes];
	diff_t  diff_s4 [L2Lanes];
	tpar_t  t_s4;
	coord_t a_s5    [L2Lanes];
	prod_t  prod_s5 [L2Lanes];
	tpar_t  t_s5;
	coord_t r_s6    [L2Lanes];
	tpar_t  t_s6;

	// Level 3 operands and registers
	coord_t l3_a [L3Lanes];
	coord_t l3_b [L3Lanes];
	coord_t a_s7    [L3Lanes];
	diff_t  diff_s7 [L3Lanes];
	tpar_t  t_s7;
	coord_t a_s8    [L3Lanes];
	prod_t  prod_s8 [L3Lanes];
	coord_t r_s9    [L3Lanes];

	// Load a stage when it is empty or the stage after it moves
	assign adv9 = !valid_s9 || rsp_ready;
	assign adv8 = !valid_s8 || adv9;
	assign adv7 = !valid_s7 || adv8;
	assign adv6 = !valid_s6 || adv7;
	assign adv5 = !valid_s5 || adv6;
	assign adv4 = !valid_s4 || adv5;
	assign adv3 = !valid_s3 || adv4;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;
	assign req_ready = adv1;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= req_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
			if (adv5) valid_s5 <= valid_s4;
			if (adv6) valid_s6 <= valid_s5;
			if (adv7) valid_s7 <= valid_s6;
			if (adv8) valid_s8 <= valid_s7;
			if (adv9) valid_s9 <= valid_s8;
		end
	end

	// Level 1 pairs: (p0,p1) (p1,p2) (p2,p3) for x, then for y
	always_comb begin
		l1_a[0] = req.p0_x;  l1_b[0] = req.p1_x;
		l1_a[1] = req.p1_x;  l1_b[1] = req.p2_x;
		l1_a[2] = req.p2_x;  l1_b[2] = req.p3_x;
		l1_a[3] = req.p0_y;  l1_b[3] = req.p1_y;
		l1_a[4] = req.p1_y;  l1_b[4] = req.p2_y;
		l1_a[5] = req.p2_y;  l1_b[5] = req.p3_y;
	end

	// Level 1: difference, multiply, shift and add
	always_ff @(posedge clk) begin
		if (adv1) begin
			for (int i = 0; i < L1Lanes; i++) begin
				a_s1[i]    <= l1_a[i];
				diff_s1[i] <= coord_diff(l1_a[i], l1_b[i]);
			end
			t_s1 <= req.t_frac;
		end
		if (adv2) begin
			for (int i = 0; i < L1Lanes; i++) begin
				a_s2[i]    <= a_s1[i];
				prod_s2[i] <= scale_diff(diff_s1[i], t_s1);
			end
			t_s2 <= t_s1;
		end
		if (adv3) begin
			for (int i = 0; i < L1Lanes; i++) begin
				r_s3[i] <= lerp_sum(a_s2[i], prod_s2[i]);
			end
			t_s3 <= t_s2;
		end
	end

	// Level 2 pairs from level 1 results
	always_comb begin
		l2_a[0] = r_s3[0];  l2_b[0] = r_s3[1];
		l2_a[1] = r_s3[1];  l2_b[1] = r_s3[2];
		l2_a[2] = r_s3[3];  l2_b[2] = r_s3[4];
		l2_a[3] = r_s3[4];  l2_b[3] = r_s3[5];
	end

	// Level 2: difference, multiply, shift and add
	always_ff @(posedge clk) begin
		if (adv4) begin
			for (int i = 0; i < L2Lanes; i++) begin
				a_s4[i]    <= l2_a[i];
				diff_s4[i] <= coord_diff(l2_a[i], l2_b[i]);
			end
			t_s4 <= t_s3;
		end
		if (adv5) begin
			for (int i = 0; i < L2Lanes; i++) begin
				a_s5[i]    <= a_s4[i];
				prod_s5[i] <= scale_diff(diff_s4[i], t_s4);
			end
			t_s5 <= t_s4;
		end
		if (adv6) begin
			for (int i = 0; i < L2Lanes; i++) begin
				r_s6[i] <= lerp_sum(a_s5[i], prod_s5[i]);
			end
			t_s6 <= t_s5;
		end
	end

	// Level 3 pairs: one for x, one for y
	always_comb begin
		l3_a[0] = r_s6[0];  l3_b[0] = r_s6[1];
		l3_a[1] = r_s6[2];  l3_b[1] = r_s6[3];
	end

	// Level 3: difference, multiply, shift and add into the output register
	always_ff @(posedge clk) begin
		if (adv7) begin
			for (int i = 0; i < L3Lanes; i++) begin
				a_s7[i]    <= l3_a[i];
				diff_s7[i] <= coord_diff(l3_a[i], l3_b[i]);
			end
			t_s7 <= t_s6;
		end
		if (adv8) begin
			for (int i = 0; i < L3Lanes; i++) begin
				a_s8[i]    <= a_s7[i];
				prod_s8[i] <= scale_diff(diff_s7[i], t_s7);
			end
		end
		if (adv9) begin
			for (int i = 0; i < L3Lanes; i++) begin
				r_s9[i] <= lerp_sum(a_s8[i], prod_s8[i]);
			end
		end
	end

	// Drive the result item
	assign rsp_valid     = valid_s9;
	assign rsp.point_x   = r_s9[0];
	assign rsp.point_y   = r_s9[1];

endmodule

### design/cbez_checker.sv
// Port-level checks for the cubic Bezier point evaluator, bound to the top.
// Depends on cbez_pkg and cubic_bezier_point_eval.
module cbez_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input cbez_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input cbez_pkg::rsp_t rsp
);
	import cbez_pkg::*;

	// Hold a stalled result item
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result item changed or dropped while stalled");

	// An empty output stage lets the whole pipe move
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("input stalled with an empty output stage");

	// A ready consumer never stalls the input
	a_ready_through: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ready |-> req_ready)
		else $error("input stalled while the consumer is ready");

	// With no back pressure an accepted item always shows up at the output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && rsp_ready) ##1 rsp_ready ##1 rsp_ready
		##1 rsp_ready ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
		##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
		else $error("result item missing at the expected latency");

endmodule

bind cubic_bezier_point_eval cbez_checker u_cbez_checker (.*);

### sim/cbez_point_checker.sv
// Checker for the cubic Bezier point evaluator: watches both channels,
// predicts each curve point and compares results in order. Depends on cbez_pkg.
module cbez_point_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_ready,
	input  cbez_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_ready,
	input  cbez_pkg::rsp_t rsp,
	output int unsigned    errors,
	output int unsigned    outstanding
);
	import cbez_pkg::*;

	rsp_t exp_points[$];

	// One lerp step: a + floor((b - a) * t / 2^16), computed wide
	function automatic coord_t lerp_q16(coord_t a, coord_t b, tpar_t t);
		longint d;
		longint p;
		d = longint'(b) - longint'(a);
		p = d * longint'(t);
		return coord_t'(longint'(a) + (p >>> FracW));
	endfunction

	// Three de Casteljau levels on one axis
	function automatic coord_t casteljau_axis(coord_t c0, coord_t c1, coord_t c2, coord_t c3,
		tpar_t t);
		coord_t q0;
		coord_t q1;
		coord_t q2;
		coord_t l0;
		coord_t l1;
		q0 = lerp_q16(c0, c1, t);
		q1 = lerp_q16(c1, c2, t);
		q2 = lerp_q16(c2, c3, t);
		l0 = lerp_q16(q0, q1, t);
		l1 = lerp_q16(q1, q2, t);
		return lerp_q16(l0, l1, t);
	endfunction

	function automatic rsp_t bezier_point(req_t r);
		rsp_t o;
		o.point_x = casteljau_axis(r.p0_x, r.p1_x, r.p2_x, r.p3_x, r.t_frac);
		o.point_y = casteljau_axis(r.p0_y, r.p1_y, r.p2_y, r.p3_y, r.t_frac);
		return o;
	endfunction

	// Clear on reset; queue a prediction per accepted item, check each accepted result
	always @(posedge clk) begin
		rsp_t want;
		if (!arst_n) begin
			exp_points.delete();
			errors      = 0;
			outstanding <= 0;
		end else begin
			if (req_valid && req_ready)
				exp_points = {exp_points, bezier_point(req)};
			if (rsp_valid && rsp_ready) begin
				if (exp_points.size() == 0) begin
					errors++;
					$display("%0t: unexpected result x=%h y=%h", $time,
						rsp.point_x, rsp.point_y);
				end else begin
					want = exp_points.pop_front();
					if (rsp.point_x !== want.point_x) begin
						errors++;
						$display("%0t: point_x expected %h got %h", $time,
							want.point_x, rsp.point_x);
					end
					if (rsp.point_y !== want.point_y) begin
						errors++;
						$display("%0t: point_y expected %h got %h", $time,
							want.point_y, rsp.point_y);
					end
				end
			end
			outstanding <= $unsigned(exp_points.size());
		end
	end

endmodule

### sim/tb.sv
// Top of the cubic Bezier evaluator bench: clock, reset, item stimulus,
// output back-pressure and the verdict. Depends on cbez_pkg and cbez_point_checker.
module tb;
	import cbez_pkg::*;

	localparam int unsigned RandomItems = 1750;
	localparam int unsigned CycleLimit  = 400000;
	localparam int unsigned HoldCycles  = 300;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_ready;
	rsp_t        rsp;
	int unsigned errors;
	int unsigned outstanding;
	bit          random_phase;
	bit          long_hold;

	cubic_bezier_point_eval dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	cbez_point_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic req_t curve(coord_t ax, coord_t ay, coord_t bx, coord_t by,
		coord_t cx, coord_t cy, coord_t dx, coord_t dy, tpar_t t);
		req_t r;
		r.p0_x = ax; r.p0_y = ay;
		r.p1_x = bx; r.p1_y = by;
		r.p2_x = cx; r.p2_y = cy;
		r.p3_x = dx; r.p3_y = dy;
		r.t_frac = t;
		return r;
	endfunction

	// Mix of extremes, small values around zero and full-range words
	function automatic coord_t rand_coord();
		int v;
		case ($urandom_range(0, 9))
			0: return coord_t'(32'h8000_0000);
			1: return coord_t'(32'h7FFF_FFFF);
			2: return '0;
			3: begin
				v = int'($urandom_range(0, 511));
				return coord_t'(v - 256);
			end
			default: return coord_t'($urandom());
		endcase
	endfunction

	function automatic tpar_t rand_t();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return tpar_t'(1);
			default: return tpar_t'($urandom());
		endcase
	endfunction

	function automatic req_t rand_curve();
		return curve(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_t());
	endfunction

	// Present one item and hold it until accepted
	task automatic offer(input req_t item);
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	// Stimulus and verdict
	initial begin : stim
		int unsigned burst_left;
		int unsigned gap;
		coord_t      mn;
		coord_t      mx;
		mn = coord_t'(32'h8000_0000);
		mx = coord_t'(32'h7FFF_FFFF);
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req          = '0;
		random_phase = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// t of zero returns p0 exactly
		offer(curve(32'h0001_0000, -32'sh0002_0000, mx, mn, mn, mx, 32'h1234_5678,
			32'h7654_3210, 16'h0000));
		offer(curve(mn, mx, mx, mn, mx, mn, mn, mx, 16'h0000));
		// t just below one only approaches p3
		offer(curve(mn, mx, mx, mn, mn, mx, mx, mn, 16'hFFFF));
		offer(curve(mn, mn, mn, mn, mx, mx, mx, mx, 16'hFFFF));
		offer(curve('0, '0, '0, '0, mx, mn, mx, mn, 16'hFFFF));
		// Extreme coordinates, largest differences in both directions
		offer(curve(mn, mn, mn, mn, mn, mn, mn, mn, 16'h8000));
		offer(curve(mx, mx, mx, mx, mx, mx, mx, mx, 16'h8000));
		offer(curve(mn, mx, mx, mn, mn, mx, mx, mn, 16'h8000));
		offer(curve(mx, mn, mn, mx, mx, mn, mn, mx, 16'h0001));
		offer(curve(mn, mx, mx, mn, mn, mx, mx, mn, 16'h5555));
		offer(curve(mx, mn, mn, mx, mx, mn, mn, mx, 16'hAAAA));
		// Floor rounding on small negative and positive differences
		offer(curve('0, '0, -32'sd1, 32'sd1, -32'sd2, 32'sd2, -32'sd3, 32'sd3, 16'h0001));
		offer(curve(32'sd5, -32'sd5, -32'sd7, 32'sd7, 32'sd3, -32'sd3, -32'sd1, 32'sd1,
			16'h7FFF));
		offer(curve(-32'sd1, -32'sd1, '0, '0, -32'sd1, -32'sd1, '0, '0, 16'hC001));
		// Straight line, all-zero points and a mixed bit-pattern curve
		offer(curve('0, '0, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0002_0000,
			32'h0003_0000, 32'h0003_0000, 16'h4000));
		offer(curve('0, '0, '0, '0, '0, '0, '0, '0, 16'hFFFF));
		offer(curve(32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_FFFF,
			32'hFFFF_0000, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h3333_3333, 16'h9249));

		// Random items in bursts with gaps
		random_phase = 1'b1;
		burst_left   = 0;
		for (int unsigned n = 0; n < RandomItems; n++) begin
			offer(rand_curve());
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap        = long_hold ? 0 : $urandom_range(0, 8);
				if (gap != 0) begin
					req_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end else begin
				burst_left--;
			end
		end
		req_valid <= 1'b0;

		// Let the last prediction land, drain, then allow the pipeline latency to pass
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (24) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Output back-pressure: random modes, with one long hold-off once the random phase starts
	initial begin : sink
		bit          hold_pending;
		int unsigned mode;
		int unsigned span;
		bit          r;
		rsp_ready    = 1'b0;
		long_hold    = 1'b0;
		hold_pending = 1'b1;
		forever begin
			if (hold_pending && random_phase) begin
				@(posedge clk);
				rsp_ready <= 1'b0;
				long_hold <= 1'b1;
				repeat (HoldCycles) @(posedge clk);
				long_hold <= 1'b0;
				hold_pending = 1'b0;
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 200);
			for (int unsigned i = 0; i < span; i++) begin
				case (mode)
					0: r = 1'b1;
					1: r = $urandom_range(0, 1);
					2: r = ($urandom_range(0, 7) == 0);
					default: r = (i % 3 != 0);
				endcase
				@(posedge clk);
				rsp_ready <= r;
			end
		end
	end

	// Stop a hung run
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CycleLimit) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

endmodule
